// File: rtl/fqr_pkg.sv
// Package for the quadratic residue test: field constants, exponent, state types.
// Used by fqr_mulmod and field_quadratic_residue_test. No dependencies.
package fqr_pkg;

	localparam int LimbW = 64;
	localparam int LimbN = 4;
	localparam int IdxW = 2;
	localparam int FieldW = 256;
	localparam int DigW = 32;
	localparam int DigN = FieldW / DigW;
	localparam int DigIdxW = 3;

	localparam logic [FieldW-1:0] PRIME =
		256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
	localparam logic [FieldW-1:0] HALF_EXP = (PRIME - 256'd1) >> 1;
	// 2^256 - p = 2^32 + 977
	localparam logic [DigW:0] FOLD = 33'h1_000003D1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LOADW,
		ST_REDUCE,
		ST_SQR,
		ST_SQRW,
		ST_MUL,
		ST_MULW,
		ST_STORE,
		ST_CHECK,
		ST_CHECKW
	} fqr_state_t;

	typedef enum logic [2:0] {
		MM_IDLE,
		MM_PROD,
		MM_FOLD1,
		MM_FOLD2,
		MM_FINAL
	} mm_state_t;

	typedef struct packed {
		logic start;
		logic done;
	} mm_ctl_t;

endpackage

// File: rtl/field_quadratic_residue_test.sv
// Quadratic residue test mod the secp256k1 prime by Euler's criterion.
// A test runs 256 squarings and 249 multiplications on the shared multiplier plus the
// load, reduce, store and check steps; done is high once they finish after the
// flagged limb's transfer. A non-flagged limb is only written to the operand store.
// Throughput: one test at a time; busy blocks input until the result strobe.
// Reset clears control state; stores stay unset. Depends on fqr_pkg, fqr_ram, fqr_mulmod.
module field_quadratic_residue_test import fqr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [LimbW-1:0] limb,
	input  logic             last_limb,
	output logic             done,
	output logic             is_residue
);

	fqr_state_t         st_q, st_d;
	logic [IdxW-1:0]    cnt_q;
	logic [IdxW-1:0]    rd_q;
	logic [7:0]         bit_q;
	logic [FieldW-1:0]  base_q;
	logic [FieldW-1:0]  acc_q;
	logic               op_we, pa_we;
	logic [IdxW-1:0]    op_addr, pa_addr;
	logic [LimbW-1:0]   op_rdata, pa_rdata, op_wdata;
	logic               accept;
	mm_ctl_t            mm;
	logic [FieldW-1:0]  mm_b, mm_r;
	logic [FieldW:0]    sub;
	logic               one_q;

	assign accept = start && !busy;
	assign sub = {1'b0, base_q} - {1'b0, PRIME};

	// Operand store and power accumulator memories.
	assign op_we = accept;
	assign op_addr = accept ? cnt_q : rd_q;
	assign op_wdata = limb;
	fqr_ram #(.Width(LimbW), .Depth(LimbN)) u_op (
		.clk(clk), .we(op_we), .addr(op_addr), .wdata(op_wdata), .rdata(op_rdata));

	assign pa_we = (st_q == ST_STORE);
	assign pa_addr = rd_q;
	fqr_ram #(.Width(LimbW), .Depth(LimbN)) u_pa (
		.clk(clk), .we(pa_we), .addr(pa_addr),
		.wdata(acc_q[FieldW-1-32'(rd_q)*LimbW -: LimbW]), .rdata(pa_rdata));

	// Multiplier: squaring or multiply by the base.
	assign mm_b = (st_q == ST_MUL) ? base_q : acc_q;
	assign mm.start = (st_q == ST_SQR) || (st_q == ST_MUL);
	fqr_mulmod u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm.start), .a(acc_q), .b(mm_b),
		.done(mm.done), .r(mm_r));

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (accept && last_limb) st_d = ST_LOAD;
			ST_LOAD: st_d = ST_LOADW;
			ST_LOADW: if (rd_q == IdxW'(LimbN - 1)) st_d = ST_REDUCE; else st_d = ST_LOAD;
			ST_REDUCE: st_d = ST_SQR;
			ST_SQR: st_d = ST_SQRW;
			ST_SQRW: begin
				if (mm.done) begin
					if (HALF_EXP[bit_q]) st_d = ST_MUL;
					else if (bit_q == 8'd0) st_d = ST_STORE;
					else st_d = ST_SQR;
				end
			end
			ST_MUL: st_d = ST_MULW;
			ST_MULW: begin
				if (mm.done) begin
					if (bit_q == 8'd0) st_d = ST_STORE;
					else st_d = ST_SQR;
				end
			end
			ST_STORE: if (rd_q == IdxW'(LimbN - 1)) st_d = ST_CHECK;
			ST_CHECK: st_d = ST_CHECKW;
			ST_CHECKW: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		busy = (st_q != ST_IDLE);
		done = (st_q == ST_CHECKW);
		is_residue = one_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			rd_q <= '0;
			bit_q <= '0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				cnt_q <= last_limb ? '0 : cnt_q + 1'b1;
				rd_q <= '0;
			end
			if (st_q == ST_LOADW || st_q == ST_STORE) begin
				rd_q <= rd_q + 1'b1;
			end
			if (st_q == ST_REDUCE) begin
				bit_q <= 8'd255;
			end
			if ((st_q == ST_SQRW && mm.done && !HALF_EXP[bit_q]) ||
					(st_q == ST_MULW && mm.done)) begin
				if (bit_q != 8'd0) bit_q <= bit_q - 1'b1;
			end
		end
	end

	// Data registers: base load, accumulator, final check.
	always_ff @(posedge clk) begin
		if (st_q == ST_LOADW) begin
			base_q <= {base_q[FieldW-LimbW-1:0], op_rdata};
		end
		if (st_q == ST_REDUCE) begin
			if (!sub[FieldW]) base_q <= sub[FieldW-1:0];
			acc_q <= FieldW'(1);
		end
		if ((st_q == ST_SQRW || st_q == ST_MULW) && mm.done) begin
			acc_q <= mm_r;
		end
		if (st_q == ST_CHECK) begin
			one_q <= (acc_q == FieldW'(1));
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == ST_CHECK)
		else $error("result without check");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SQRW && mm.done && bit_q == 8'd0) |-> HALF_EXP[0])
		else $error("last exponent bit mismatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_limb) |=> busy)
		else $error("test did not start");

endmodule

// File: rtl/fqr_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module fqr_ram #(
	parameter int Width = 64,
	parameter int Depth = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Read before write: registered read of the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: rtl/fqr_mulmod.sv
// Shared modular multiplier mod the secp256k1 prime, one 32x32 digit product
// per cycle, then two folds and a final reduction. Depends on fqr_pkg.
module fqr_mulmod import fqr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FieldW-1:0] a,
	input  logic [FieldW-1:0] b,
	output logic              done,
	output logic [FieldW-1:0] r
);

	mm_state_t               st_q;
	logic [DigIdxW-1:0]      dig_q;
	logic [DigIdxW-1:0]      bdig_q;
	logic [2*FieldW-1:0]     prod_q;
	logic [FieldW-1:0]       a_q;
	logic [FieldW-1:0]       b_q;
	logic [FieldW+DigW+1:0]  w_q;
	logic [2*DigW-1:0]       pp;
	logic [DigW-1:0]         adig;
	logic [DigW-1:0]         bdig;
	logic [DigIdxW:0]        col;
	logic [FieldW+DigW+1:0]  fold1;
	logic [FieldW+DigW+1:0]  fold2;
	logic [FieldW:0]         sub;

	// One digit of a times one digit of b, placed at their combined column.
	assign adig = a_q[dig_q*DigW +: DigW];
	assign bdig = b_q[bdig_q*DigW +: DigW];
	assign pp = (2*DigW)'(adig) * (2*DigW)'(bdig);
	assign col = {1'b0, dig_q} + {1'b0, bdig_q};

	// Fold the high part back: hi * 2^256 == hi * (2^32 + 977).
	assign fold1 = (FieldW+DigW+2)'(prod_q[FieldW-1:0])
		+ (FieldW+DigW+2)'(prod_q[2*FieldW-1:FieldW]) * (FieldW+DigW+2)'(FOLD);
	assign fold2 = (FieldW+DigW+2)'(w_q[FieldW-1:0])
		+ (FieldW+DigW+2)'(w_q[FieldW+DigW+1:FieldW]) * (FieldW+DigW+2)'(FOLD);
	assign sub = {1'b0, w_q[FieldW-1:0]} - {1'b0, PRIME};

	// Sequencer: product digits, two folds, final reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MM_IDLE;
			dig_q <= '0;
			bdig_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				MM_IDLE: begin
					if (start) begin
						st_q <= MM_PROD;
						dig_q <= '0;
						bdig_q <= '0;
					end
				end
				MM_PROD: begin
					bdig_q <= bdig_q + 1'b1;
					if (bdig_q == DigIdxW'(DigN - 1)) begin
						dig_q <= dig_q + 1'b1;
						if (dig_q == DigIdxW'(DigN - 1)) begin
							st_q <= MM_FOLD1;
						end
					end
				end
				MM_FOLD1: st_q <= MM_FOLD2;
				MM_FOLD2: st_q <= MM_FINAL;
				MM_FINAL: begin
					st_q <= MM_IDLE;
					done <= 1'b1;
				end
				default: st_q <= MM_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			MM_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
					prod_q <= '0;
				end
			end
			MM_PROD: prod_q <= prod_q
				+ ((2*FieldW)'(pp) << (col * DigW));
			MM_FOLD1: w_q <= fold1;
			MM_FOLD2: w_q <= fold2;
			MM_FINAL: begin
				// A carry out of the second fold leaves a small low part: add 2^256 - p.
				if (w_q[FieldW]) begin
					r <= w_q[FieldW-1:0] + FieldW'(FOLD);
				end else if (!sub[FieldW]) begin
					r <= sub[FieldW-1:0];
				end else begin
					r <= w_q[FieldW-1:0];
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) == MM_FINAL)
		else $error("multiplier done without final step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == MM_FOLD2) |-> !w_q[FieldW+DigW+1])
		else $error("fold overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("double done");

endmodule

// File: sim/tb_field_quadratic_residue_test.sv
// Testbench for field_quadratic_residue_test: drives limb transfers and checks is_residue.
// Depends on fqr_pkg for the field prime and the Euler exponent; needs only the RTL.
// A scoreboard class models the limb store and the modular power for each flagged limb.

class residue_scoreboard;
	logic [63:0]       limb_store [4];
	int unsigned       next_pos;
	bit                pending_answers [$];
	int unsigned       mismatches;
	int unsigned       tests_checked;
	int unsigned       residues_seen;

	function new();
		next_pos = 0;
		mismatches = 0;
		tests_checked = 0;
		residues_seen = 0;
	endfunction

	// The element's power to (p-1)/2 mod p, by left-to-right square-and-multiply.
	function bit euler_test(input logic [255:0] element);
		logic [511:0] prod;
		logic [255:0] base_val;
		logic [255:0] power;
		base_val = element;
		if (base_val >= fqr_pkg::PRIME)
			base_val = base_val - fqr_pkg::PRIME;
		power = 256'd1;
		for (int k = 255; k >= 0; k--) begin
			prod = {256'd0, power} * {256'd0, power};
			power = 256'(prod % {256'd0, fqr_pkg::PRIME});
			if (fqr_pkg::HALF_EXP[k]) begin
				prod = {256'd0, power} * {256'd0, base_val};
				power = 256'(prod % {256'd0, fqr_pkg::PRIME});
			end
		end
		return power == 256'd1;
	endfunction

	// Note one accepted limb; a flagged limb queues the expected answer.
	function void note_limb(input logic [63:0] value, input logic flagged);
		limb_store[next_pos] = value;
		next_pos = (next_pos + 1) % 4;
		if (flagged) begin
			next_pos = 0;
			pending_answers.push_back(euler_test({limb_store[0], limb_store[1],
				limb_store[2], limb_store[3]}));
		end
	endfunction

	// Compare one strobed result with the oldest expected answer.
	function void check_answer(input logic actual);
		bit wanted;
		if (pending_answers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result is_residue=%b", actual);
			return;
		end
		wanted = pending_answers.pop_front();
		tests_checked++;
		if (actual === 1'b1)
			residues_seen++;
		if (actual !== wanted) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: test %0d is_residue expected %b actual %b",
					tests_checked, wanted, actual);
		end
	endfunction
endclass

module tb_field_quadratic_residue_test;
	import fqr_pkg::*;

	localparam int TotalItems = 290;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [LimbW-1:0] limb;
	logic             last_limb;
	logic             done;
	logic             is_residue;

	residue_scoreboard sb;
	int unsigned       items_sent;
	bit                gaps_on;

	field_quadratic_residue_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.limb(limb),
		.last_limb(last_limb),
		.done(done),
		.is_residue(is_residue)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit well above the slowest correct run.
	initial begin
		#(12 * 50_000_000);
		$display("end of test: mismatches");
		$finish;
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_answer(is_residue);
	end

	// Offer one limb, wait for its transfer, and note it.
	task automatic send_limb(input logic [63:0] value, input logic flagged);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		start <= 1'b1;
		limb <= value;
		last_limb <= flagged;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_limb(value, flagged);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_element(input logic [255:0] element);
		for (int i = 3; i >= 0; i--)
			send_limb(element[i*64 +: 64], i == 0);
	endtask

	function automatic logic [63:0] random_limb();
		return {$urandom(), $urandom()};
	endfunction

	// Stimulus: directed elements, then random sequences.
	initial begin
		int unsigned seq_len;
		logic [255:0] element;
		sb = new();
		items_sent = 0;
		gaps_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		limb = '0;
		last_limb = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Zero, one, a small square, the prime, p - 1, p + 1 and all ones.
		send_element(256'd0);
		send_element(256'd1);
		send_element(256'd4);
		send_element(PRIME);
		send_element(PRIME - 256'd1);
		send_element(PRIME + 256'd1);
		send_element({256{1'b1}});
		// Early last mark: the older limbs stay in the store.
		send_limb(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_limb(64'd9, 1'b1);
		// More than four limbs without a mark wrap the position.
		for (int i = 0; i < 5; i++)
			send_limb(random_limb(), 1'b0);
		send_limb(64'd0, 1'b1);

		// Random part: mostly whole elements, some broken sequences.
		while (items_sent < TotalItems) begin
			if (items_sent > TotalItems * 4 / 5)
				gaps_on = 1'b0;
			if ($urandom_range(0, 4) != 0) begin
				element = {random_limb(), random_limb(), random_limb(), random_limb()};
				if ($urandom_range(0, 7) == 0)
					element[255:64] = '1;
				send_element(element);
			end else begin
				seq_len = $urandom_range(1, 6);
				for (int i = 1; i <= seq_len; i++)
					send_limb(random_limb(), i == seq_len);
			end
		end
		start <= 1'b0;

		// Drain outstanding results, then allow a short settling time.
		for (int w = 0; w < 200000 && sb.pending_answers.size() != 0; w++)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d limb transfers; checked %0d residue tests, %0d residues.",
			items_sent, sb.tests_checked, sb.residues_seen);
		if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("Mismatches: %0d, results still owed: %0d",
				sb.mismatches, sb.pending_answers.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
